// ===== rtl/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and constants of the Mandelbrot escape-time engine: number
// formats, window geometry, register indexes and the microcode word layout.
// ----------------------------------------------------------------------------
package mbet_pkg;

  // Fixed-point format: signed Q4.28.
  localparam int Q_FRAC = 28;

  // Window geometry, given as powers of two.
  localparam int WIN_WIDTH_LOG2  = 10;
  localparam int WIN_HEIGHT_LOG2 = 10;
  localparam int WIN_WIDTH       = 1 << WIN_WIDTH_LOG2;
  localparam int WIN_HEIGHT      = 1 << WIN_HEIGHT_LOG2;

  // Escape threshold |z|^2 > 4.0, in the Q8.56 product format.
  localparam logic [63:0] ESCAPE_MAG = 64'd1 << (2 * Q_FRAC + 2);

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REAL_MIN   = 3'd0,
    REG_REAL_MAX   = 3'd1,
    REG_IMAG_MIN   = 3'd2,
    REG_IMAG_MAX   = 3'd3,
    REG_ITER_LIMIT = 3'd4,
    REG_POINTER_X  = 3'd5,
    REG_POINTER_Y  = 3'd6
  } reg_index_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] real_min;
    logic signed [31:0] real_max;
    logic signed [31:0] imag_min;
    logic signed [31:0] imag_max;
    logic [11:0]        iter_limit;
    logic [9:0]         pointer_x;
    logic [9:0]         pointer_y;
  } cfg_t;

  // Microprogram step addresses.
  localparam int UADDR_W = 3;

  typedef enum logic [UADDR_W-1:0] {
    STEP_MAP_MUL   = 3'd0,
    STEP_MAP_ADD   = 3'd1,
    STEP_FIRST_MUL = 3'd2,
    STEP_FIRST_UPD = 3'd3,
    STEP_LOOP_MUL  = 3'd4,
    STEP_LOOP_TEST = 3'd5,
    STEP_DONE      = 3'd6
  } step_t;

  // Branch conditions of a control word.
  typedef enum logic [1:0] {
    COND_NONE       = 2'd0,
    COND_LIMIT_ZERO = 2'd1,
    COND_EXIT       = 2'd2
  } cond_t;

  // One microcode control word.
  typedef struct packed {
    logic  ld_map;    // register the view-mapping products
    logic  ld_start;  // load starting z, clear the iteration count
    logic  ld_c;      // form c from the mapping products
    logic  ld_prod;   // register the products of z
    logic  ld_z;      // write the updated z
    logic  inc_n;     // count a completed update unless it escaped
    logic  finish;    // deliver the result and go idle
    cond_t cond;
    step_t next;
    step_t jump;
  } ctrl_t;

  // Status returned by the datapath for branching and the result.
  typedef struct packed {
    logic        limit_zero;
    logic        exit_loop;
    logic [11:0] count;
  } status_t;

endpackage

// ===== rtl/mbet_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mbet_cfg_regs
// Configuration register file. Takes one register write per transfer on the
// configuration channel; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module mbet_cfg_regs import mbet_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // The register file can always take a write.
  assign cfg_ready = 1'b1;

  // Register writes, with the documented reset view.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.real_min   <= 32'shE000_0000;
      cfg.real_max   <= 32'sh1000_0000;
      cfg.imag_min   <= 32'shE800_0000;
      cfg.imag_max   <= 32'sh1800_0000;
      cfg.iter_limit <= 12'd256;
      cfg.pointer_x  <= 10'd0;
      cfg.pointer_y  <= 10'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_REAL_MIN:   cfg.real_min   <= $signed(cfg_data);
        REG_REAL_MAX:   cfg.real_max   <= $signed(cfg_data);
        REG_IMAG_MIN:   cfg.imag_min   <= $signed(cfg_data);
        REG_IMAG_MAX:   cfg.imag_max   <= $signed(cfg_data);
        REG_ITER_LIMIT: cfg.iter_limit <= cfg_data[11:0];
        REG_POINTER_X:  cfg.pointer_x  <= cfg_data[9:0];
        REG_POINTER_Y:  cfg.pointer_y  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mbet_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// mbet_ucode_rom
// Read-only microprogram of the engine. Each step gives one control word with
// datapath enables, a branch condition and the two successor addresses.
// ----------------------------------------------------------------------------
module mbet_ucode_rom import mbet_pkg::*; (
  input  step_t addr,
  output ctrl_t word
);

  // Program: map the pixel and finish at once if the limit is zero; else run one
  // update, then alternate multiply and update-with-test until the point escapes or the limit is reached.
  always_comb begin
    word      = '0;
    word.cond = COND_NONE;
    word.next = STEP_DONE;
    word.jump = STEP_DONE;
    case (addr)
      STEP_MAP_MUL: begin
        word.ld_map   = 1'b1;
        word.ld_start = 1'b1;
        word.next     = STEP_MAP_ADD;
      end
      STEP_MAP_ADD: begin
        word.ld_c = 1'b1;
        word.cond = COND_LIMIT_ZERO;
        word.next = STEP_FIRST_MUL;
      end
      STEP_FIRST_MUL: begin
        word.ld_prod = 1'b1;
        word.next    = STEP_FIRST_UPD;
      end
      STEP_FIRST_UPD: begin
        word.ld_z = 1'b1;
        word.next = STEP_LOOP_MUL;
      end
      STEP_LOOP_MUL: begin
        word.ld_prod = 1'b1;
        word.next    = STEP_LOOP_TEST;
      end
      STEP_LOOP_TEST: begin
        word.ld_z  = 1'b1;
        word.inc_n = 1'b1;
        word.cond  = COND_EXIT;
        word.next  = STEP_LOOP_MUL;
      end
      STEP_DONE: begin
        word.finish = 1'b1;
      end
      default: begin
        word.finish = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/mbet_datapath.sv =====
// ----------------------------------------------------------------------------
// mbet_datapath
// Arithmetic of the engine: view mapping, starting z, the product bank for
// z*z, the saturating update and the escape test, all under microcode control.
// ----------------------------------------------------------------------------
module mbet_datapath import mbet_pkg::*; (
  input  logic       clk,
  input  logic       accept,
  input  logic       active,
  input  logic [9:0] pixel_col,
  input  logic [9:0] pixel_row,
  input  cfg_t       cfg,
  input  ctrl_t      ctrl,
  output status_t    status
);

  localparam int ZR_SHIFT = Q_FRAC - 1 - WIN_WIDTH_LOG2;
  localparam int ZI_SHIFT = Q_FRAC - WIN_HEIGHT_LOG2;
  localparam logic signed [39:0] ZR_BIAS = 40'sd1 <<< (Q_FRAC - 2);
  localparam logic signed [39:0] ZI_BIAS = 40'sd1 <<< (Q_FRAC - 1);
  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = $signed(64'hFFFF_FFFF_8000_0000);

  // Clamp a wide signed value to the 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [9:0]         col_r;
  logic [9:0]         row_r;
  logic signed [43:0] map_pr;
  logic signed [43:0] map_pi;
  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic signed [31:0] zr;
  logic signed [31:0] zi;
  logic signed [63:0] p_rr;
  logic signed [63:0] p_ii;
  logic signed [63:0] p_ri;
  logic [11:0]        n;

  logic signed [32:0] span_r;
  logic signed [32:0] span_i;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic signed [39:0] zr_start;
  logic signed [39:0] zi_start;
  logic signed [63:0] p_diff;
  logic signed [31:0] zr_next;
  logic signed [31:0] zi_next;
  logic [63:0]        mag;
  logic               escape;
  logic               limit_hit;

  // View spans and pointer offsets from the configuration.
  assign span_r   = 33'(cfg.real_max) - 33'(cfg.real_min);
  assign span_i   = 33'(cfg.imag_max) - 33'(cfg.imag_min);
  assign dx       = $signed({6'd0, cfg.pointer_x}) - 16'(WIN_WIDTH);
  assign dy       = $signed({6'd0, cfg.pointer_y}) - 16'(WIN_HEIGHT);
  assign zr_start = (40'(dx) <<< ZR_SHIFT) + ZR_BIAS;
  assign zi_start = (40'(dy) <<< ZI_SHIFT) + ZI_BIAS;

  // Update of z from the registered products, rounded toward minus infinity.
  assign p_diff  = p_rr - p_ii;
  assign zr_next = sat32((p_diff >>> Q_FRAC) + 64'(cr));
  assign zi_next = sat32((p_ri >>> (Q_FRAC - 1)) + 64'(ci));

  // Escape test on the squares of the current z, exact in Q8.56.
  assign mag       = $unsigned(p_rr) + $unsigned(p_ii);
  assign escape    = mag > ESCAPE_MAG;
  assign limit_hit = (13'(n) + 13'd1) == 13'(cfg.iter_limit);

  // Capture of the pixel on an input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= pixel_col;
      row_r <= pixel_row;
    end
  end

  // Mapping products and c.
  always_ff @(posedge clk) begin
    if (active && ctrl.ld_map) begin
      map_pr <= 44'(span_r) * 44'($signed({1'b0, col_r}));
      map_pi <= 44'(span_i) * 44'($signed({1'b0, row_r}));
    end
    if (active && ctrl.ld_c) begin
      cr <= sat32(64'(map_pr >>> WIN_WIDTH_LOG2) + 64'(cfg.real_min));
      ci <= sat32(64'(map_pi >>> WIN_HEIGHT_LOG2) + 64'(cfg.imag_min));
    end
  end

  // Product bank and z registers.
  always_ff @(posedge clk) begin
    if (active && ctrl.ld_prod) begin
      p_rr <= 64'(zr) * 64'(zr);
      p_ii <= 64'(zi) * 64'(zi);
      p_ri <= 64'(zr) * 64'(zi);
    end
    if (active && ctrl.ld_start) begin
      zr <= sat32(64'(zr_start));
      zi <= sat32(64'(zi_start));
    end else if (active && ctrl.ld_z) begin
      zr <= zr_next;
      zi <= zi_next;
    end
  end

  // Iteration counter: counts updates that stayed inside the threshold.
  always_ff @(posedge clk) begin
    if (active && ctrl.ld_start) begin
      n <= 12'd0;
    end else if (active && ctrl.inc_n && !escape) begin
      n <= n + 12'd1;
    end
  end

  // Status for branching and the result.
  assign status.limit_zero = cfg.iter_limit == 12'd0;
  assign status.exit_loop  = escape || limit_hit;
  assign status.count      = n;

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Mandelbrot escape-time engine in signed Q4.28 fixed point, driven by a
// microcoded sequencer over a multiplier datapath.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high while busy is low; busy then stays high
// until the result is produced. The result appears on iteration_count for
// exactly one cycle with done high, and the receiver cannot stall it, so it
// must be captured in that cycle. The count is the number of loop updates after
// the first, less one when the point escapes; done goes high in the cycle after
// the last busy cycle. Each update goes through the registered product bank and
// then the saturating update adder before the next multiply. The default limit
// is 256. Configuration writes are always accepted and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbet_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [9:0]             pixel_col,
  input  logic [9:0]             pixel_row,
  output logic                   done,
  output logic [11:0]            iteration_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t status;
  step_t   pc;
  logic    accept;
  logic    taken;

  assign accept = start && !busy;

  mbet_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbet_ucode_rom u_ucode_rom (
    .addr (pc),
    .word (ctrl)
  );

  mbet_datapath u_datapath (
    .clk       (clk),
    .accept    (accept),
    .active    (busy),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .status    (status)
  );

  // Branch condition selected by the current control word.
  always_comb begin
    case (ctrl.cond)
      COND_NONE:       taken = 1'b0;
      COND_LIMIT_ZERO: taken = status.limit_zero;
      COND_EXIT:       taken = status.exit_loop;
      default:         taken = 1'b0;
    endcase
  end

  // Step counter, busy flag and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pc   <= STEP_MAP_MUL;
    end else begin
      done <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
        pc   <= STEP_MAP_MUL;
      end else if (busy) begin
        if (ctrl.finish) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (taken) begin
          pc <= ctrl.jump;
        end else begin
          pc <= ctrl.next;
        end
      end
    end
  end

  // Result register, loaded when the program finishes.
  always_ff @(posedge clk) begin
    if (busy && ctrl.finish) begin
      iteration_count <= status.count;
    end
  end

endmodule
